[sv/sre_pkg.sv]
// Shared constants, types and the tail-length table for the segment reassembly engine.
// Depends on nothing; used by segment_reassembly_engine by scoped names and imported by the checker and testbench.
package sre_pkg;

  // Geometry of the segments and of the message store
  localparam int SEG_PAYLOAD   = 59;
  localparam int STORE_DEPTH   = 256;
  localparam int SEGMENT_LIMIT = 8;

  // Derived widths
  localparam int BMP_W   = SEGMENT_LIMIT - 1;              // received-segment bitmap
  localparam int LIM_W   = SEGMENT_LIMIT;                  // 2^segment_count compare
  localparam int CNT_W   = $clog2(SEGMENT_LIMIT);          // validated count / index
  localparam int CPY_W   = $clog2(SEG_PAYLOAD + 1);        // bytes to copy
  localparam int ADDR_W  = $clog2(STORE_DEPTH);            // store index
  localparam int WADDR_W = $clog2(SEG_PAYLOAD * 256 + 1);  // raw payload*index+position
  localparam int LEN_N   = 256;                            // total_length code space

  // Result status codes
  typedef enum logic [1:0] {
    ST_DROP     = 2'd0,
    ST_ACCEPT   = 2'd1,
    ST_COMPLETE = 2'd2,
    ST_READ     = 2'd3
  } status_e;

  // Function codes of an input item
  localparam logic FUNC_PAYLOAD = 1'b0;
  localparam logic FUNC_READ    = 1'b1;

  // Tail byte count of the last segment, (len-1) mod payload + 1, zero for len 0
  typedef logic [CPY_W-1:0] tail_lut_t [LEN_N];

  function automatic tail_lut_t build_tail_lut();
    tail_lut_t lut;
    int        r;
    for (int i = 0; i < LEN_N; i++) begin
      if (i == 0) begin
        lut[i] = '0;
      end else begin
        r = i - 1;
        for (int k = 0; k < LEN_N; k++) begin
          if (r >= SEG_PAYLOAD) r = r - SEG_PAYLOAD;
        end
        lut[i] = CPY_W'(r + 1);
      end
    end
    return lut;
  endfunction

  localparam tail_lut_t TAIL_LUT = build_tail_lut();

endpackage

[sv/segment_reassembly_engine.sv]
// Segment reassembly engine: header rules, bitmap tracking and the message store.
// Depends on sre_pkg (constants, status codes, tail table).
//
//  channel | direction | handshake                  | payload
//  in      | input     | in_valid_i / in_stall_o    | func .. read_address
//  out     | output    | out_valid_o / out_stall_i  | status, message_length, read_data
//
// One item per cycle sustained while out_stall_i is low; a result passes through the read
// stage with the registered store read and then through the output register.
// The store is a 256 x 8 synchronous memory with one access (write or read) per item;
// a flop per entry marks it written, so unwritten entries read as zero after reset.
// Reset is asynchronous and active low and clears all control state and the marks.
// While a result waits on out_stall_i one more item is taken into the read stage,
// after which in_stall_o rises.
module segment_reassembly_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [15:0] seq_number_i,
  input  logic [7:0]  total_length_i,
  input  logic [7:0]  segment_count_i,
  input  logic [7:0]  segment_index_i,
  input  logic [5:0]  byte_position_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  read_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  message_length_o,
  output logic [7:0]  read_data_o
);

  // Reassembly state
  logic                        partial_q, partial_d;
  logic [sre_pkg::BMP_W-1:0]   bitmap_q, bitmap_d;
  logic [15:0]                 cur_seq_q, cur_seq_d;
  logic [7:0]                  cmp_len_q, cmp_len_d;
  logic                        acc_q, acc_d;
  logic [sre_pkg::CPY_W-1:0]   copy_q, copy_d;
  logic                        comp_q, comp_d;

  // Store, its written marks and the read stage
  logic [7:0]                  mem [sre_pkg::STORE_DEPTH];
  logic [sre_pkg::STORE_DEPTH-1:0] wr_mark_q;
  logic [7:0]                  rd_q;
  logic                        rd_mark_q;

  logic                        s1_vld_q;
  sre_pkg::status_e            s1_status_q;
  logic [7:0]                  s1_len_q;
  logic                        s1_rd_q;

  logic                        out_vld_q;
  sre_pkg::status_e            out_status_q;
  logic [7:0]                  out_len_q;
  logic [7:0]                  out_data_q;

  // Handshake
  logic in_acc, s1_adv, out_acc;
  assign out_acc    = out_vld_q && !out_stall_i;
  assign s1_adv     = !out_vld_q || !out_stall_i;
  assign in_stall_o = s1_vld_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Header check
  logic [sre_pkg::CNT_W-1:0]   cnt_s, idx_s;
  logic [sre_pkg::WADDR_W-1:0] span;
  logic                        hdr_ok, restart, match, do_hdr;
  logic [sre_pkg::BMP_W-1:0]   idx_bit, bmp_match;
  logic [sre_pkg::LIM_W-1:0]   full_pat, bmp_inc;
  logic                        last_seg, all_seen;

  assign cnt_s   = segment_count_i[sre_pkg::CNT_W-1:0];
  assign idx_s   = segment_index_i[sre_pkg::CNT_W-1:0];
  assign span    = sre_pkg::WADDR_W'(segment_count_i) * sre_pkg::WADDR_W'(sre_pkg::SEG_PAYLOAD);
  assign hdr_ok  = (segment_count_i != 8'd0)
                && (32'(segment_count_i) < sre_pkg::SEGMENT_LIMIT)
                && (segment_index_i < segment_count_i)
                && (span >= sre_pkg::WADDR_W'(total_length_i));
  assign restart  = !partial_q || (seq_number_i > cur_seq_q) || (seq_number_i == 16'd0);
  assign match    = seq_number_i == cur_seq_q;
  assign do_hdr   = in_acc && (func_i == sre_pkg::FUNC_PAYLOAD) && (byte_position_i == 6'd0);
  assign last_seg = segment_index_i == (segment_count_i - 8'd1);
  assign idx_bit  = sre_pkg::BMP_W'(1) << idx_s;
  assign bmp_match = bitmap_q | idx_bit;
  assign bmp_inc  = {1'b0, bmp_match} + sre_pkg::LIM_W'(1);
  assign full_pat = sre_pkg::LIM_W'(1) << cnt_s;
  assign all_seen = bmp_inc == full_pat;

  // Header evaluation and latched segment flags
  logic                      h_acc, h_comp;
  logic [sre_pkg::CPY_W-1:0] h_copy;

  always_comb begin
    h_acc     = 1'b0;
    h_copy    = '0;
    h_comp    = 1'b0;
    partial_d = partial_q;
    bitmap_d  = bitmap_q;
    cur_seq_d = cur_seq_q;
    if (hdr_ok) begin
      if (restart) begin
        h_acc = 1'b1;
        if (segment_count_i == 8'd1) begin
          h_copy = sre_pkg::CPY_W'(total_length_i);
          h_comp = 1'b1;
        end else begin
          partial_d = 1'b1;
          bitmap_d  = idx_bit;
          cur_seq_d = seq_number_i;
          h_copy    = last_seg ? '0 : sre_pkg::CPY_W'(sre_pkg::SEG_PAYLOAD);
        end
      end else if (match) begin
        h_acc    = 1'b1;
        bitmap_d = bmp_match;
        h_copy   = last_seg ? sre_pkg::TAIL_LUT[total_length_i]
                            : sre_pkg::CPY_W'(sre_pkg::SEG_PAYLOAD);
        if (all_seen) begin
          h_comp    = 1'b1;
          partial_d = 1'b0;
        end
      end
    end
    if (!do_hdr) begin
      partial_d = partial_q;
      bitmap_d  = bitmap_q;
      cur_seq_d = cur_seq_q;
    end
  end

  // Payload byte: store write, completion and status
  logic                        e_acc, e_comp, done, wr_en, rd_en, rd_in_range;
  logic [sre_pkg::CPY_W-1:0]   e_copy;
  logic [sre_pkg::WADDR_W-1:0] waddr;
  sre_pkg::status_e            st;

  assign e_acc  = do_hdr ? h_acc  : acc_q;
  assign e_copy = do_hdr ? h_copy : copy_q;
  assign e_comp = do_hdr ? h_comp : comp_q;
  assign waddr  = sre_pkg::WADDR_W'(segment_index_i) * sre_pkg::WADDR_W'(sre_pkg::SEG_PAYLOAD)
                + sre_pkg::WADDR_W'(byte_position_i);
  assign done   = e_acc && e_comp && (32'(byte_position_i) == sre_pkg::SEG_PAYLOAD - 1);
  assign wr_en  = in_acc && (func_i == sre_pkg::FUNC_PAYLOAD) && e_acc
               && (sre_pkg::CPY_W'(byte_position_i) < e_copy)
               && (32'(waddr) < sre_pkg::STORE_DEPTH);
  assign rd_en  = in_acc && (func_i == sre_pkg::FUNC_READ);
  assign rd_in_range = 32'(read_address_i) < sre_pkg::STORE_DEPTH;

  always_comb begin
    acc_d     = acc_q;
    copy_d    = copy_q;
    comp_d    = comp_q;
    cmp_len_d = cmp_len_q;
    st        = sre_pkg::ST_READ;
    if (in_acc && (func_i == sre_pkg::FUNC_PAYLOAD)) begin
      acc_d  = e_acc;
      copy_d = e_copy;
      comp_d = e_comp && !done;
      if (!e_acc) begin
        st = sre_pkg::ST_DROP;
      end else if (done) begin
        st        = sre_pkg::ST_COMPLETE;
        cmp_len_d = total_length_i;
      end else begin
        st = sre_pkg::ST_ACCEPT;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= 1'b0;
      bitmap_q  <= '0;
      cur_seq_q <= '0;
      cmp_len_q <= '0;
      acc_q     <= 1'b0;
      copy_q    <= '0;
      comp_q    <= 1'b0;
    end else begin
      partial_q <= partial_d;
      bitmap_q  <= bitmap_d;
      cur_seq_q <= cur_seq_d;
      cmp_len_q <= cmp_len_d;
      acc_q     <= acc_d;
      copy_q    <= copy_d;
      comp_q    <= comp_d;
    end
  end

  // Message store, one access per item, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[sre_pkg::ADDR_W'(waddr)] <= data_byte_i;
    end
    if (rd_en) begin
      rd_q <= mem[sre_pkg::ADDR_W'(read_address_i)];
    end
  end

  // Written marks stand in for clearing the store at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_mark_q <= '0;
      rd_mark_q <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_mark_q[sre_pkg::ADDR_W'(waddr)] <= 1'b1;
      end
      if (rd_en) begin
        rd_mark_q <= rd_in_range && wr_mark_q[sre_pkg::ADDR_W'(read_address_i)];
      end
    end
  end

  // Read stage and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_vld_q && s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (out_acc) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_status_q <= st;
      s1_len_q    <= cmp_len_d;
      s1_rd_q     <= func_i == sre_pkg::FUNC_READ;
    end
    if (s1_vld_q && s1_adv) begin
      out_status_q <= s1_status_q;
      out_len_q    <= s1_len_q;
      out_data_q   <= (s1_rd_q && rd_mark_q) ? rd_q : 8'd0;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign status_o         = out_status_q;
  assign message_length_o = out_len_q;
  assign read_data_o      = out_data_q;

  // Checks
  a_bitmap_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    partial_q |-> (bitmap_q != '0))
    else $error("reception active with empty bitmap");

  a_comp_needs_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    comp_q |-> acc_q)
    else $error("completion pending on a dropped segment");

  a_bad_hdr_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_hdr && !hdr_ok) |=> (partial_q == $past(partial_q)) && (bitmap_q == $past(bitmap_q)))
    else $error("invalid header changed reception state");

  a_data_only_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_status_q != sre_pkg::ST_READ)) |-> (out_data_q == 8'd0))
    else $error("read data on a payload result");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && out_vld_q && out_stall_i) |-> in_stall_o)
    else $error("item taken with both stages held");

endmodule

[dv/segment_reassembly_checker.sv]
`timescale 1ns / 100ps
// Checker for the segment reassembly engine: watches both channels, keeps its own copy
// of the message store and header state, predicts every result and counts mismatches.
// Depends on sre_pkg (geometry constants, status codes, function codes).
module segment_reassembly_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        func_i,
  input  logic [15:0] seq_number_i,
  input  logic [7:0]  total_length_i,
  input  logic [7:0]  segment_count_i,
  input  logic [7:0]  segment_index_i,
  input  logic [5:0]  byte_position_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  read_address_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic [7:0]  message_length_i,
  input  logic [7:0]  read_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  import sre_pkg::*;

  typedef struct {
    status_e    status;
    logic [7:0] msg_len;
    logic [7:0] rd_data;
  } result_t;

  // Shadow of the block state
  logic [7:0]       store_q [STORE_DEPTH];
  logic             rx_active;    // multi-segment message in progress
  logic [BMP_W-1:0] seg_seen;     // segments received so far
  logic [15:0]      rx_seq;       // sequence of the message in progress
  logic [7:0]       last_len;     // length of the last completed message
  logic             seg_taken;    // current segment passed the header rules
  logic [5:0]       copy_cnt;     // bytes of the current segment that get stored
  logic             seg_closes;   // current segment finishes its message

  result_t expected_q [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count_o++;
    $display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Works out the result of the item on the input ports and updates the shadow state
  function automatic result_t predict_result();
    result_t r;
    int      addr;
    r.status  = ST_DROP;
    r.rd_data = 8'd0;
    if (func_i == FUNC_READ) begin
      r.status = ST_READ;
      if (int'(read_address_i) < STORE_DEPTH) r.rd_data = store_q[read_address_i];
    end else begin
      // Header rules are applied on the first byte only
      if (byte_position_i == 6'd0) begin
        seg_taken  = 1'b0;
        copy_cnt   = 6'd0;
        seg_closes = 1'b0;
        if (segment_count_i != 8'd0 && int'(segment_count_i) < SEGMENT_LIMIT &&
            segment_index_i < segment_count_i &&
            int'(segment_count_i) * SEG_PAYLOAD >= int'(total_length_i)) begin
          if (!rx_active || seq_number_i > rx_seq || seq_number_i == 16'd0) begin
            // Restart: single segment completes, otherwise open a new message
            seg_taken = 1'b1;
            if (segment_count_i == 8'd1) begin
              copy_cnt   = 6'(total_length_i);
              seg_closes = 1'b1;
            end else begin
              rx_active = 1'b1;
              seg_seen  = BMP_W'(1 << segment_index_i);
              rx_seq    = seq_number_i;
              copy_cnt  = (segment_index_i < segment_count_i - 8'd1) ? 6'(SEG_PAYLOAD) : 6'd0;
            end
          end else if (seq_number_i == rx_seq) begin
            // Same message: record the segment, the last one carries the tail
            seg_taken = 1'b1;
            seg_seen  = seg_seen | BMP_W'(1 << segment_index_i);
            if (segment_index_i == segment_count_i - 8'd1) begin
              copy_cnt = (total_length_i == 8'd0) ? 6'd0 :
                         6'((int'(total_length_i) - 1) % SEG_PAYLOAD + 1);
            end else begin
              copy_cnt = 6'(SEG_PAYLOAD);
            end
            if (int'(seg_seen) + 1 == (1 << segment_count_i)) begin
              seg_closes = 1'b1;
              rx_active  = 1'b0;
            end
          end
        end
      end
      if (seg_taken) begin
        r.status = ST_ACCEPT;
        if (byte_position_i < copy_cnt) begin
          addr = SEG_PAYLOAD * int'(segment_index_i) + int'(byte_position_i);
          if (addr < STORE_DEPTH) store_q[addr] = data_byte_i;
        end
        if (int'(byte_position_i) == SEG_PAYLOAD - 1 && seg_closes) begin
          last_len   = total_length_i;
          seg_closes = 1'b0;
          r.status   = ST_COMPLETE;
        end
      end
    end
    r.msg_len = last_len;
    return r;
  endfunction

  // Predict on every accepted item, compare on every accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < STORE_DEPTH; i++) store_q[i] = 8'd0;
      rx_active  = 1'b0;
      seg_seen   = '0;
      rx_seq     = 16'd0;
      last_len   = 8'd0;
      seg_taken  = 1'b0;
      copy_cnt   = 6'd0;
      seg_closes = 1'b0;
      expected_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) expected_q.push_back(predict_result());
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with none expected, status", int'(status_i), -1);
        end else begin
          want = expected_q.pop_front();
          if (status_i !== want.status)
            report_mismatch("status", int'(status_i), int'(want.status));
          if (message_length_i !== want.msg_len)
            report_mismatch("message_length", int'(message_length_i), int'(want.msg_len));
          if (read_data_i !== want.rd_data)
            report_mismatch("read_data", int'(read_data_i), int'(want.rd_data));
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

[dv/tb_segment_reassembly_engine.sv]
`timescale 1ns / 100ps
// Testbench top for the segment reassembly engine: drives directed and random items with
// random idling on both channels and prints the verdict from the checker's count.
// Depends on sre_pkg, segment_reassembly_engine and segment_reassembly_checker.
module tb_segment_reassembly_engine;
  import sre_pkg::*;

  localparam int ITEM_TARGET = 1650;
  localparam int QUIET_FROM  = 1350;    // no idling on either side past this item
  localparam int DRAIN_AT    = 800;     // sender waits for all results once here
  localparam int TAIL_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        func;
  logic [15:0] seq_number;
  logic [7:0]  total_length;
  logic [7:0]  segment_count;
  logic [7:0]  segment_index;
  logic [5:0]  byte_position;
  logic [7:0]  data_byte;
  logic [7:0]  read_address;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [7:0]  message_length;
  logic [7:0]  read_data;

  int          fail_count;
  int          pending;
  int          items_sent = 0;
  int          idle_pct   = 0;
  int          cycle_count = 0;
  bit          quiet      = 1'b0;
  bit          drained    = 1'b0;
  logic [15:0] next_seq   = 16'd1;

  segment_reassembly_engine dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .func_i           (func),
    .seq_number_i     (seq_number),
    .total_length_i   (total_length),
    .segment_count_i  (segment_count),
    .segment_index_i  (segment_index),
    .byte_position_i  (byte_position),
    .data_byte_i      (data_byte),
    .read_address_i   (read_address),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .message_length_o (message_length),
    .read_data_o      (read_data)
  );

  segment_reassembly_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .func_i           (func),
    .seq_number_i     (seq_number),
    .total_length_i   (total_length),
    .segment_count_i  (segment_count),
    .segment_index_i  (segment_index),
    .byte_position_i  (byte_position),
    .data_byte_i      (data_byte),
    .read_address_i   (read_address),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .status_i         (status),
    .message_length_i (message_length),
    .read_data_i      (read_data),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("segment_reassembly_engine: mismatch");
      $finish;
    end
  end

  // Receiver stalls in bursts of random length
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && !quiet && $urandom_range(0, 99) < idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one item, with an optional idle burst first, and wait until it is taken
  task automatic send_item(input logic fn, input logic [15:0] seq, input logic [7:0] len,
                           input logic [7:0] cnt, input logic [7:0] idx,
                           input logic [5:0] pos, input logic [7:0] dat,
                           input logic [7:0] raddr);
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    func          <= fn;
    seq_number    <= seq;
    total_length  <= len;
    segment_count <= cnt;
    segment_index <= idx;
    byte_position <= pos;
    data_byte     <= dat;
    read_address  <= raddr;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_byte(input logic [15:0] seq, input logic [7:0] len,
                           input logic [7:0] cnt, input logic [7:0] idx,
                           input logic [5:0] pos, input logic [7:0] dat);
    send_item(FUNC_PAYLOAD, seq, len, cnt, idx, pos, dat, 8'($urandom));
  endtask

  task automatic send_read(input logic [7:0] raddr);
    send_item(FUNC_READ, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              6'($urandom), 8'($urandom), raddr);
  endtask

  // Sender holds off until every expected result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // One segment: byte 0, then either every position or a sparse walk up to the last
  task automatic send_segment(input logic [15:0] seq, input logic [7:0] len,
                              input logic [7:0] cnt, input logic [7:0] idx);
    int pos;
    bit full_run;
    bit done;
    full_run = ($urandom_range(0, 7) == 0);
    pos      = 0;
    done     = 1'b0;
    while (!done) begin
      // later bytes sometimes carry a garbled header, which must be ignored
      if (pos != 0 && $urandom_range(0, 15) == 0)
        send_byte(16'($urandom), 8'($urandom), 8'($urandom), idx, 6'(pos), 8'($urandom));
      else
        send_byte(seq, len, cnt, idx, 6'(pos), 8'($urandom));
      if ($urandom_range(0, 9) == 0) send_read(8'($urandom));
      if (pos == SEG_PAYLOAD - 1) begin
        done = 1'b1;
      end else begin
        pos = full_run ? pos + 1 : pos + $urandom_range(1, 20);
        if (pos > SEG_PAYLOAD - 1) pos = SEG_PAYLOAD - 1;
      end
    end
    // positions past the payload
    if ($urandom_range(0, 5) == 0)
      send_byte(seq, len, cnt, idx, 6'($urandom_range(SEG_PAYLOAD, 63)), 8'($urandom));
  endtask

  // A whole message in random segment order, sometimes broken on purpose
  task automatic send_message();
    logic [15:0] seq;
    logic [7:0]  cnt;
    logic [7:0]  len;
    int          order [7];
    int          max_len;
    int          n;
    int          j;
    int          tmp;
    int          variant;
    case ($urandom_range(0, 9))
      0: seq = 16'd0;
      1: begin
        next_seq = 16'($urandom);
        seq      = next_seq;
      end
      default: begin
        next_seq = next_seq + 16'($urandom_range(1, 3));
        seq      = next_seq;
      end
    endcase
    cnt     = ($urandom_range(0, 3) == 0) ? 8'd1 : 8'($urandom_range(2, SEGMENT_LIMIT - 1));
    max_len = int'(cnt) * SEG_PAYLOAD;
    if (max_len > 255) max_len = 255;
    len = 8'($urandom_range(0, max_len));
    for (int k = 0; k < 7; k++) order[k] = k;
    if ($urandom_range(0, 3) != 0) begin
      for (int k = int'(cnt) - 1; k > 0; k--) begin
        j        = $urandom_range(0, k);
        tmp      = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
    end
    // missing segment, repeated segment, or a stale segment slipped in
    variant = $urandom_range(0, 9);
    n       = (variant == 0) ? int'(cnt) - 1 : int'(cnt);
    for (int k = 0; k < n; k++) begin
      if (variant == 2 && k == 1) send_segment(seq - 16'd1, len, cnt, 8'(order[0]));
      send_segment(seq, len, cnt, 8'(order[k]));
    end
    if (variant == 1) send_segment(seq, len, cnt, 8'(order[0]));
  endtask

  // Reset, directed items, random messages and noise, then the verdict
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    func          = FUNC_PAYLOAD;
    seq_number    = 16'd0;
    total_length  = 8'd0;
    segment_count = 8'd0;
    segment_index = 8'd0;
    byte_position = 6'd0;
    data_byte     = 8'd0;
    read_address  = 8'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // mid-segment byte with nothing accepted, read of a cleared entry
    send_byte(16'd7, 8'd10, 8'd1, 8'd0, 6'd5, 8'hAA);
    send_read(8'd0);
    // header rejects: zero count, count at limit, index past count, length too long
    send_byte(16'd1, 8'd10, 8'd0, 8'd0, 6'd0, 8'h01);
    send_byte(16'd1, 8'd10, 8'd8, 8'd0, 6'd0, 8'h02);
    send_byte(16'd1, 8'd10, 8'd3, 8'd3, 6'd0, 8'h03);
    send_byte(16'd1, 8'd60, 8'd1, 8'd0, 6'd0, 8'h04);
    // single segment: stored bytes, byte past the length, completion, beyond payload
    send_byte(16'hFFFF, 8'd3, 8'd1, 8'd0, 6'd0, 8'hFF);
    send_byte(16'hFFFF, 8'd3, 8'd1, 8'd0, 6'd2, 8'h00);
    send_byte(16'hFFFF, 8'd3, 8'd1, 8'd0, 6'd3, 8'h5A);
    send_byte(16'hFFFF, 8'd3, 8'd1, 8'd0, 6'd58, 8'h6B);
    send_byte(16'hFFFF, 8'd3, 8'd1, 8'd0, 6'd63, 8'h7C);
    // two segments, last first; a later byte with a different header
    send_byte(16'd5, 8'd100, 8'd2, 8'd1, 6'd0, 8'h11);
    send_byte(16'd5, 8'd100, 8'd2, 8'd1, 6'd58, 8'h12);
    send_byte(16'd5, 8'd100, 8'd2, 8'd0, 6'd0, 8'h22);
    send_byte(16'd9, 8'd200, 8'd7, 8'd0, 6'd10, 8'h33);
    send_byte(16'd5, 8'd100, 8'd2, 8'd0, 6'd58, 8'h44);
    // restart on idle, stale sequence, larger sequence, sequence zero
    send_byte(16'd10, 8'd150, 8'd3, 8'd0, 6'd0, 8'h55);
    send_byte(16'd9, 8'd150, 8'd3, 8'd1, 6'd0, 8'h56);
    send_byte(16'd11, 8'd150, 8'd3, 8'd1, 6'd0, 8'h57);
    send_byte(16'd0, 8'd150, 8'd3, 8'd2, 6'd0, 8'h58);
    // tail of the last segment at the top of the store
    send_byte(16'd12, 8'd255, 8'd5, 8'd0, 6'd0, 8'h60);
    send_byte(16'd12, 8'd255, 8'd5, 8'd4, 6'd0, 8'h61);
    send_byte(16'd12, 8'd255, 8'd5, 8'd4, 6'd18, 8'hC3);
    // zero-length message
    send_byte(16'd13, 8'd0, 8'd1, 8'd0, 6'd0, 8'h70);
    send_byte(16'd13, 8'd0, 8'd1, 8'd0, 6'd58, 8'h71);
    send_read(8'd254);

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= QUIET_FROM) quiet = 1'b1;
      case ((items_sent / 200) % 3)
        0:       idle_pct = 20;
        1:       idle_pct = 0;
        default: idle_pct = 45;
      endcase
      if (items_sent >= DRAIN_AT && !drained) begin
        wait_drained();
        drained = 1'b1;
      end
      if ($urandom_range(0, 4) == 0) begin
        // noise: random fields throughout
        repeat ($urandom_range(1, 5))
          send_item(1'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 6'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        send_message();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("segment_reassembly_engine: match");
    end else begin
      $display("segment_reassembly_engine: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/sre_pkg.sv
sv/segment_reassembly_engine.sv
dv/segment_reassembly_checker.sv
dv/tb_segment_reassembly_engine.sv
